FILE: hw/rtl/cht_pkg.sv
package cht_pkg;

    localparam int TABLE_DEPTH_DEF = 256;

    localparam int HASH_W      = 22;
    localparam int HOME_W      = 10;
    localparam int NAME_HIGH_W = 64;
    localparam int NAME_LOW_W  = 24;
    localparam int NAME_W      = NAME_HIGH_W + NAME_LOW_W;
    localparam int CHAR_W      = 8;
    localparam int NUM_CHARS   = NAME_W / CHAR_W;

    localparam int HOME_MULT   = 23;
    localparam int PROD_W      = 15;
    localparam int RECIP_SHIFT = 28;
    localparam int RECIP_W     = 25;
    localparam int Q_W         = PROD_W + RECIP_W - RECIP_SHIFT;

    localparam logic CMD_SAVE   = 1'b0;
    localparam logic CMD_LOOKUP = 1'b1;

    localparam logic [1:0] KIND_10    = 2'd0;
    localparam logic [1:0] KIND_12    = 2'd1;
    localparam logic [1:0] KIND_22    = 2'd2;
    localparam logic [1:0] KIND_SPARE = 2'd3;

    typedef enum logic [1:0] {
        RES_NONE,
        RES_SAVE_HIT,
        RES_LOOKUP_HIT,
        RES_FULL
    } res_kind_t;

    typedef struct packed {
        logic [HASH_W-1:0]      hash;
        logic [NAME_HIGH_W-1:0] name_high;
        logic [NAME_LOW_W-1:0]  name_low;
    } entry_t;

    typedef struct packed {
        logic      capture;
        logic      home_div;
        logic      home_qd;
        logic      home_mod;
        logic      advance;
        logic      count_probe;
        logic      clr_write;
        logic      ins_write;
        logic      res_load;
        res_kind_t res_kind;
    } cmd_t;

    typedef struct packed {
        logic skip;
        logic is_lookup;
        logic slot_empty;
        logic slot_match;
        logic probe_last;
        logic clr_last;
    } status_t;

endpackage

FILE: hw/rtl/cht_ctrl.sv
module cht_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  cht_pkg::status_t status,
    output cht_pkg::cmd_t    cmd,
    output logic            busy,
    output logic            done
);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DIV,
        ST_QD,
        ST_MOD,
        ST_FETCH,
        ST_PROBE
    } state_t;

    state_t state_reg, state_next;
    logic   busy_reg;
    logic   done_reg;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.res_kind = cht_pkg::RES_NONE;
        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.clr_write = 1'b1;
                if (status.clr_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.capture = 1'b1;
                    if (status.skip)
                    begin
                        cmd.res_load = 1'b1;
                    end
                    else
                    begin
                        state_next = ST_DIV;
                    end
                end
            end
            ST_DIV:
            begin
                cmd.home_div = 1'b1;
                state_next   = ST_QD;
            end
            ST_QD:
            begin
                cmd.home_qd = 1'b1;
                state_next  = ST_MOD;
            end
            ST_MOD:
            begin
                cmd.home_mod = 1'b1;
                state_next   = ST_FETCH;
            end
            ST_FETCH:
            begin
                cmd.advance = 1'b1;
                state_next  = ST_PROBE;
            end
            ST_PROBE:
            begin
                if (status.slot_empty)
                begin
                    cmd.ins_write = !status.is_lookup;
                    cmd.res_load  = 1'b1;
                    state_next    = ST_IDLE;
                end
                else if (status.slot_match)
                begin
                    cmd.res_load = 1'b1;
                    cmd.res_kind = status.is_lookup ? cht_pkg::RES_LOOKUP_HIT
                                                    : cht_pkg::RES_SAVE_HIT;
                    state_next   = ST_IDLE;
                end
                else if (status.probe_last)
                begin
                    cmd.res_load = 1'b1;
                    cmd.res_kind = cht_pkg::RES_FULL;
                    state_next   = ST_IDLE;
                end
                else
                begin
                    cmd.advance     = 1'b1;
                    cmd.count_probe = 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
        if (busy_reg)
        begin
            cmd.capture = cmd.capture & 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            busy_reg  <= 1'b1;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            busy_reg  <= (state_next != ST_IDLE);
            done_reg  <= cmd.res_load;
        end
    end

    assign busy = busy_reg;
    assign done = done_reg;

endmodule

FILE: hw/rtl/cht_datapath.sv
module cht_datapath #(
    parameter int TABLE_DEPTH = cht_pkg::TABLE_DEPTH_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  cht_pkg::cmd_t                     cmd,
    output cht_pkg::status_t                  status,
    input  logic                              command,
    input  logic [cht_pkg::HASH_W-1:0]        hash,
    input  logic [1:0]                        hash_kind,
    input  logic [cht_pkg::NAME_HIGH_W-1:0]   name_high,
    input  logic [cht_pkg::NAME_LOW_W-1:0]    name_low,
    output logic                              found,
    output logic                              table_full,
    output logic [cht_pkg::NAME_HIGH_W-1:0]   found_name_high,
    output logic [cht_pkg::NAME_LOW_W-1:0]    found_name_low
);

    localparam int IDX_W   = $clog2(TABLE_DEPTH);
    localparam int DEPTH_W = $clog2(TABLE_DEPTH + 1);
    localparam int QD_W    = cht_pkg::Q_W + DEPTH_W;
    localparam logic [cht_pkg::RECIP_W-1:0] RECIP =
        cht_pkg::RECIP_W'(((64'd1 << cht_pkg::RECIP_SHIFT) + TABLE_DEPTH - 1) / TABLE_DEPTH);
    localparam logic [IDX_W-1:0]   LAST_IDX = IDX_W'(TABLE_DEPTH - 1);
    localparam logic [DEPTH_W-1:0] DEPTH_V  = DEPTH_W'(TABLE_DEPTH);
    localparam int QP_W = cht_pkg::PROD_W + cht_pkg::RECIP_W;

    cht_pkg::entry_t mem [TABLE_DEPTH];
    cht_pkg::entry_t rd_data_reg;

    logic                              cmd_reg;
    logic [cht_pkg::HASH_W-1:0]        hash_reg;
    logic [1:0]                        kind_reg;
    logic [cht_pkg::NAME_HIGH_W-1:0]   nh_reg;
    logic [cht_pkg::NAME_LOW_W-1:0]    nl_reg;

    logic [cht_pkg::PROD_W-1:0]        prod_reg;
    logic [QP_W-1:0]                   qprod_reg;
    logic [QD_W-1:0]                   qd_reg;

    logic [IDX_W-1:0]                  idx_reg;
    logic [IDX_W-1:0]                  cur_reg;
    logic [IDX_W-1:0]                  n_reg;
    logic [IDX_W-1:0]                  idx_inc;

    logic                              found_reg;
    logic                              full_reg;
    logic [cht_pkg::NAME_HIGH_W-1:0]   fnh_reg;
    logic [cht_pkg::NAME_LOW_W-1:0]    fnl_reg;

    logic [cht_pkg::NAME_W-1:0]        name_raw;
    logic [cht_pkg::NAME_W-1:0]        name_norm;
    logic                              ended;
    logic [cht_pkg::HOME_W-1:0]        h10;
    logic [QD_W-1:0]                   diff;
    logic [cht_pkg::HASH_W-1:0]        slot_shifted;
    logic                              mem_we;
    logic [IDX_W-1:0]                  wr_addr;
    cht_pkg::entry_t                   wr_data;

    always_comb
    begin
        name_raw  = {name_high, name_low};
        name_norm = '0;
        ended     = 1'b0;
        for (int k = 0; k < cht_pkg::NUM_CHARS; k++)
        begin
            if (!ended)
            begin
                name_norm[cht_pkg::CHAR_W*(cht_pkg::NUM_CHARS-1-k) +: cht_pkg::CHAR_W] =
                    name_raw[cht_pkg::CHAR_W*(cht_pkg::NUM_CHARS-1-k) +: cht_pkg::CHAR_W];
                if (name_raw[cht_pkg::CHAR_W*(cht_pkg::NUM_CHARS-1-k) +: cht_pkg::CHAR_W]
                    == '0)
                begin
                    ended = 1'b1;
                end
            end
        end
    end

    always_comb
    begin
        h10 = hash[21:12];
        if (command == cht_pkg::CMD_LOOKUP)
        begin
            case (hash_kind)
                cht_pkg::KIND_10: h10 = hash[9:0];
                cht_pkg::KIND_12: h10 = hash[11:2];
                default:          h10 = hash[21:12];
            endcase
        end
    end

    always_comb
    begin
        case (kind_reg)
            cht_pkg::KIND_10: slot_shifted = {12'd0, rd_data_reg.hash[21:12]};
            cht_pkg::KIND_12: slot_shifted = {10'd0, rd_data_reg.hash[21:10]};
            default:          slot_shifted = rd_data_reg.hash;
        endcase
    end

    assign diff    = QD_W'(prod_reg) - qd_reg;
    assign idx_inc = (idx_reg == LAST_IDX) ? '0 : idx_reg + 1'b1;

    assign status.skip       = (command == cht_pkg::CMD_SAVE) && (name_high[63:56] == '0);
    assign status.is_lookup  = (cmd_reg == cht_pkg::CMD_LOOKUP);
    assign status.slot_empty = (rd_data_reg.name_high[63:56] == '0);
    assign status.slot_match = (cmd_reg == cht_pkg::CMD_LOOKUP) ?
                               (slot_shifted == hash_reg) :
                               ((rd_data_reg.hash == hash_reg) &&
                                (rd_data_reg.name_high == nh_reg) &&
                                (rd_data_reg.name_low == nl_reg));
    assign status.probe_last = (n_reg == LAST_IDX);
    assign status.clr_last   = (idx_reg == LAST_IDX);

    assign mem_we  = cmd.clr_write | cmd.ins_write;
    assign wr_addr = cmd.clr_write ? idx_reg : cur_reg;
    assign wr_data = cmd.clr_write ? '0 : {hash_reg, nh_reg, nl_reg};

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[idx_reg];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            cmd_reg  <= command;
            hash_reg <= hash;
            kind_reg <= hash_kind;
            nh_reg   <= name_norm[cht_pkg::NAME_W-1 -: cht_pkg::NAME_HIGH_W];
            nl_reg   <= name_norm[cht_pkg::NAME_LOW_W-1:0];
            prod_reg <= cht_pkg::PROD_W'(h10) * cht_pkg::PROD_W'(cht_pkg::HOME_MULT);
        end
        if (cmd.home_div)
        begin
            qprod_reg <= QP_W'(prod_reg) * QP_W'(RECIP);
        end
        if (cmd.home_qd)
        begin
            qd_reg <= QD_W'(qprod_reg[cht_pkg::RECIP_SHIFT +: cht_pkg::Q_W]) * QD_W'(DEPTH_V);
        end
        if (cmd.advance)
        begin
            cur_reg <= idx_reg;
        end
        if (cmd.home_mod)
        begin
            n_reg <= '0;
        end
        else if (cmd.count_probe)
        begin
            n_reg <= n_reg + 1'b1;
        end
        if (cmd.res_load)
        begin
            found_reg <= 1'b0;
            full_reg  <= 1'b0;
            fnh_reg   <= '0;
            fnl_reg   <= '0;
            case (cmd.res_kind)
                cht_pkg::RES_SAVE_HIT:
                begin
                    found_reg <= 1'b1;
                end
                cht_pkg::RES_LOOKUP_HIT:
                begin
                    found_reg <= 1'b1;
                    fnh_reg   <= rd_data_reg.name_high;
                    fnl_reg   <= rd_data_reg.name_low;
                end
                cht_pkg::RES_FULL:
                begin
                    full_reg <= 1'b1;
                end
                default:
                begin
                    found_reg <= 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg <= '0;
        end
        else if (cmd.home_mod)
        begin
            idx_reg <= diff[IDX_W-1:0];
        end
        else if (cmd.clr_write || cmd.advance)
        begin
            idx_reg <= idx_inc;
        end
    end

    assign found           = found_reg;
    assign table_full      = full_reg;
    assign found_name_high = fnh_reg;
    assign found_name_low  = fnl_reg;

endmodule

FILE: hw/rtl/callsign_hash_table.sv
// Channel   Ports                                              Handshake
// request   command hash hash_kind name_high name_low         start & !busy
// result    found table_full found_name_high found_name_low   done, one cycle
//
// A request first reckons its home slot by a reciprocal multiply, a quotient times
// depth and a remainder, then fetches the home slot; the table RAM is then read one
// slot a cycle, up to TABLE_DEPTH slots, until an empty slot, a match or the last
// probe raises done. busy drops with done.
// A save with an empty callsign answers in the next cycle.
// After reset a clearing pass that zeroes every slot holds busy high.
// The receiver cannot stall; done is never held back for it.
module callsign_hash_table #(
    parameter int TABLE_DEPTH = cht_pkg::TABLE_DEPTH_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic                              command,
    input  logic [cht_pkg::HASH_W-1:0]        hash,
    input  logic [1:0]                        hash_kind,
    input  logic [cht_pkg::NAME_HIGH_W-1:0]   name_high,
    input  logic [cht_pkg::NAME_LOW_W-1:0]    name_low,
    output logic                              busy,
    output logic                              done,
    output logic                              found,
    output logic                              table_full,
    output logic [cht_pkg::NAME_HIGH_W-1:0]   found_name_high,
    output logic [cht_pkg::NAME_LOW_W-1:0]    found_name_low
);

    cht_pkg::cmd_t    cmd;
    cht_pkg::status_t status;

    cht_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .cmd    (cmd),
        .busy   (busy),
        .done   (done)
    );

    cht_datapath #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .status          (status),
        .command         (command),
        .hash            (hash),
        .hash_kind       (hash_kind),
        .name_high       (name_high),
        .name_low        (name_low),
        .found           (found),
        .table_full      (table_full),
        .found_name_high (found_name_high),
        .found_name_low  (found_name_low)
    );

endmodule

FILE: hw/rtl/cht_checker.sv
module cht_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              start,
    input logic                              busy,
    input logic                              done,
    input logic                              found,
    input logic                              table_full,
    input logic [cht_pkg::NAME_HIGH_W-1:0]   found_name_high,
    input logic [cht_pkg::NAME_LOW_W-1:0]    found_name_low
);

    a_accept_answers: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (busy || done))
        else $error("accepted request neither busy nor answered");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result shown while still busy");

    a_found_xor_full: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !(found && table_full))
        else $error("found and table_full both set");

    a_miss_zero_name: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !found) |-> (found_name_high == '0 && found_name_low == '0))
        else $error("nonzero name on a miss");

    a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> (!done || $past(start && !busy)))
        else $error("repeated result strobe");

endmodule

bind callsign_hash_table cht_checker u_cht_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .done            (done),
    .found           (found),
    .table_full      (table_full),
    .found_name_high (found_name_high),
    .found_name_low  (found_name_low)
);

FILE: sim/callsign_hash_table_checker.sv
`timescale 1ns / 100ps

module callsign_hash_table_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  logic                            busy,
    input  logic                            command,
    input  logic [cht_pkg::HASH_W-1:0]      hash,
    input  logic [1:0]                      hash_kind,
    input  logic [cht_pkg::NAME_HIGH_W-1:0] name_high,
    input  logic [cht_pkg::NAME_LOW_W-1:0]  name_low,
    input  logic                            done,
    input  logic                            found,
    input  logic                            table_full,
    input  logic [cht_pkg::NAME_HIGH_W-1:0] found_name_high,
    input  logic [cht_pkg::NAME_LOW_W-1:0]  found_name_low,
    output int                              mismatches,
    output int                              pending,
    output int                              checked,
    output int                              hits,
    output int                              fulls
);

    localparam int DEPTH = cht_pkg::TABLE_DEPTH_DEF;

    typedef struct packed {
        logic                       found;
        logic                       full;
        logic [cht_pkg::NAME_W-1:0] name;
    } answer_t;

    logic [cht_pkg::HASH_W-1:0] slot_hash [DEPTH];
    logic [cht_pkg::NAME_W-1:0] slot_name [DEPTH];
    int                         occupied;
    int                         fail_count;
    int                         checked_count;
    int                         hit_count;
    int                         full_count;
    answer_t                    answer_q[$];

    function automatic logic [cht_pkg::NAME_W-1:0] trim_callsign(
        logic [cht_pkg::NAME_W-1:0] raw);
        logic [cht_pkg::NAME_W-1:0] res;
        logic                       ended;
        int                         k;
        res   = raw;
        ended = 1'b0;
        for (k = cht_pkg::NUM_CHARS - 1; k >= 0; k--)
        begin
            if (ended)
                res[k*cht_pkg::CHAR_W +: cht_pkg::CHAR_W] = '0;
            else if (res[k*cht_pkg::CHAR_W +: cht_pkg::CHAR_W] == '0)
                ended = 1'b1;
        end
        return res;
    endfunction

    function automatic int home_of(int h10);
        return ((h10 & 'h3FF) * cht_pkg::HOME_MULT) % DEPTH;
    endfunction

    // Walks the table exactly as the block does and applies any insert.
    function automatic answer_t search_table(logic cmd, logic [cht_pkg::HASH_W-1:0] h,
                                             logic [1:0] kind,
                                             logic [cht_pkg::NAME_W-1:0] raw);
        answer_t                    ans;
        logic [cht_pkg::NAME_W-1:0] name;
        int                         shift;
        int                         idx;
        int                         n;
        ans = '0;
        if (cmd == cht_pkg::CMD_SAVE)
        begin
            name = trim_callsign(raw);
            if (name[cht_pkg::NAME_W-1 -: cht_pkg::CHAR_W] == '0)
                return ans;
            idx = home_of(int'(h >> 12));
            for (n = 0; n < DEPTH; n++)
            begin
                if (slot_name[idx][cht_pkg::NAME_W-1 -: cht_pkg::CHAR_W] == '0)
                begin
                    slot_hash[idx] = h;
                    slot_name[idx] = name;
                    if (occupied < DEPTH)
                        occupied++;
                    return ans;
                end
                if (slot_hash[idx] == h && slot_name[idx] == name)
                begin
                    ans.found = 1'b1;
                    return ans;
                end
                idx = (idx + 1 >= DEPTH) ? 0 : idx + 1;
            end
            ans.full = 1'b1;
        end
        else
        begin
            shift = (kind == cht_pkg::KIND_10) ? 12 : (kind == cht_pkg::KIND_12) ? 10 : 0;
            idx   = home_of(int'(h >> (12 - shift)));
            for (n = 0; n < DEPTH; n++)
            begin
                if (slot_name[idx][cht_pkg::NAME_W-1 -: cht_pkg::CHAR_W] == '0)
                    return ans;
                if ((slot_hash[idx] >> shift) == h)
                begin
                    ans.found = 1'b1;
                    ans.name  = slot_name[idx];
                    return ans;
                end
                idx = (idx + 1 >= DEPTH) ? 0 : idx + 1;
            end
            ans.full = 1'b1;
        end
        return ans;
    endfunction

    task automatic report_mismatch(string what, logic [cht_pkg::NAME_W-1:0] got,
                                   logic [cht_pkg::NAME_W-1:0] want);
        fail_count++;
        if (fail_count <= 40)
            $display("%0t: %s: got %h, expected %h", $time, what, got, want);
    endtask

    always @(posedge clk)
    begin
        answer_t want;
        int      k;
        if (!rst_n)
        begin
            for (k = 0; k < DEPTH; k++)
            begin
                slot_hash[k] = '0;
                slot_name[k] = '0;
            end
            occupied = 0;
            answer_q.delete();
        end
        else
        begin
            if (done)
            begin
                if (answer_q.size() == 0)
                    report_mismatch("result with no request pending",
                                    {found_name_high, found_name_low}, '0);
                else
                begin
                    want = answer_q.pop_front();
                    checked_count++;
                    if (want.found)
                        hit_count++;
                    if (want.full)
                        full_count++;
                    if (found !== want.found)
                        report_mismatch("found", cht_pkg::NAME_W'(found),
                                        cht_pkg::NAME_W'(want.found));
                    if (table_full !== want.full)
                        report_mismatch("table_full", cht_pkg::NAME_W'(table_full),
                                        cht_pkg::NAME_W'(want.full));
                    if (found_name_high !==
                        want.name[cht_pkg::NAME_W-1 -: cht_pkg::NAME_HIGH_W])
                        report_mismatch("found_name_high",
                                        cht_pkg::NAME_W'(found_name_high),
                                        cht_pkg::NAME_W'(want.name[cht_pkg::NAME_W-1 -:
                                                                   cht_pkg::NAME_HIGH_W]));
                    if (found_name_low !== want.name[cht_pkg::NAME_LOW_W-1:0])
                        report_mismatch("found_name_low",
                                        cht_pkg::NAME_W'(found_name_low),
                                        cht_pkg::NAME_W'(want.name[cht_pkg::NAME_LOW_W-1:0]));
                end
            end
            if (start && !busy)
                answer_q.push_back(search_table(command, hash, hash_kind,
                                                {name_high, name_low}));
        end
        mismatches <= fail_count;
        pending    <= answer_q.size();
        checked    <= checked_count;
        hits       <= hit_count;
        fulls      <= full_count;
    end

endmodule

FILE: sim/callsign_hash_table_test.sv
`timescale 1ns / 100ps

module callsign_hash_table_test;

    logic                            clk = 1'b0;
    logic                            rst_n = 1'b0;
    logic                            start = 1'b0;
    logic                            command = cht_pkg::CMD_SAVE;
    logic [cht_pkg::HASH_W-1:0]      hash = '0;
    logic [1:0]                      hash_kind = cht_pkg::KIND_10;
    logic [cht_pkg::NAME_HIGH_W-1:0] name_high = '0;
    logic [cht_pkg::NAME_LOW_W-1:0]  name_low = '0;
    logic                            busy;
    logic                            done;
    logic                            found;
    logic                            table_full;
    logic [cht_pkg::NAME_HIGH_W-1:0] found_name_high;
    logic [cht_pkg::NAME_LOW_W-1:0]  found_name_low;

    int mismatches;
    int pending;
    int checked;
    int hits;
    int fulls;

    logic [cht_pkg::HASH_W-1:0] known_hash[$];
    logic [cht_pkg::NAME_W-1:0] known_name[$];
    int                         save_count;
    int                         lookup_count;
    logic                       calm;

    always #4 clk = ~clk;

    callsign_hash_table DUT (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .command         (command),
        .hash            (hash),
        .hash_kind       (hash_kind),
        .name_high       (name_high),
        .name_low        (name_low),
        .busy            (busy),
        .done            (done),
        .found           (found),
        .table_full      (table_full),
        .found_name_high (found_name_high),
        .found_name_low  (found_name_low)
    );

    callsign_hash_table_checker result_check (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .command         (command),
        .hash            (hash),
        .hash_kind       (hash_kind),
        .name_high       (name_high),
        .name_low        (name_low),
        .done            (done),
        .found           (found),
        .table_full      (table_full),
        .found_name_high (found_name_high),
        .found_name_low  (found_name_low),
        .mismatches      (mismatches),
        .pending         (pending),
        .checked         (checked),
        .hits            (hits),
        .fulls           (fulls)
    );

    function automatic int pause_len();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 55)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    function automatic logic [cht_pkg::NAME_W-1:0] random_callsign();
        string                      alphabet;
        logic [cht_pkg::NAME_W-1:0] nm;
        int                         len;
        int                         k;
        alphabet = "ABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789/";
        if ($urandom_range(0, 4) == 0)
        begin
            nm = {$urandom, $urandom, 24'($urandom)};
            if (nm[cht_pkg::NAME_W-1 -: cht_pkg::CHAR_W] == '0)
                nm[cht_pkg::NAME_W-1 -: cht_pkg::CHAR_W] = 8'h80;
            return nm;
        end
        len = $urandom_range(1, cht_pkg::NUM_CHARS);
        nm  = '0;
        for (k = 0; k < cht_pkg::NUM_CHARS; k++)
        begin
            if (k < len)
                nm[(cht_pkg::NUM_CHARS-1-k)*cht_pkg::CHAR_W +: cht_pkg::CHAR_W] =
                    alphabet[$urandom_range(0, alphabet.len() - 1)];
            else if (k > len && $urandom_range(0, 3) == 0)
                nm[(cht_pkg::NUM_CHARS-1-k)*cht_pkg::CHAR_W +: cht_pkg::CHAR_W] =
                    8'($urandom);
        end
        return nm;
    endfunction

    task automatic send_request(logic cmd, logic [cht_pkg::HASH_W-1:0] h, logic [1:0] kind,
                                logic [cht_pkg::NAME_W-1:0] nm);
        int gap;
        gap = pause_len();
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start     <= 1'b1;
        command   <= cmd;
        hash      <= h;
        hash_kind <= kind;
        name_high <= nm[cht_pkg::NAME_W-1 -: cht_pkg::NAME_HIGH_W];
        name_low  <= nm[cht_pkg::NAME_LOW_W-1:0];
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    task automatic save_callsign(logic [cht_pkg::HASH_W-1:0] h,
                                 logic [cht_pkg::NAME_W-1:0] nm);
        send_request(cht_pkg::CMD_SAVE, h, 2'($urandom), nm);
        save_count++;
        if (nm[cht_pkg::NAME_W-1 -: cht_pkg::CHAR_W] != '0)
        begin
            known_hash.push_back(h);
            known_name.push_back(nm);
        end
    endtask

    task automatic query_hash(logic [cht_pkg::HASH_W-1:0] h, logic [1:0] kind);
        send_request(cht_pkg::CMD_LOOKUP, h, kind, {$urandom, $urandom, 24'($urandom)});
        lookup_count++;
    endtask

    task automatic random_mix(int count);
        int                         r;
        int                         k;
        int                         pick;
        logic [1:0]                 kind;
        logic [cht_pkg::HASH_W-1:0] h;
        logic [cht_pkg::NAME_W-1:0] nm;
        for (k = 0; k < count; k++)
        begin
            if (k % 64 == 0)
                calm = ($urandom_range(0, 3) == 0);
            r    = $urandom_range(0, 99);
            pick = $urandom_range(0, known_hash.size() - 1);
            if (r < 18)
                save_callsign(22'($urandom), random_callsign());
            else if (r < 24)
                save_callsign(known_hash[pick], random_callsign());
            else if (r < 30)
                // flips bit 8 of the upper ten bits: same home slot
                save_callsign(known_hash[pick] ^ 22'h100000, random_callsign());
            else if (r < 42)
                save_callsign(known_hash[pick], known_name[pick]);
            else if (r < 78)
            begin
                kind = 2'($urandom_range(0, 3));
                h    = known_hash[pick];
                if (kind == cht_pkg::KIND_10)
                    h = h >> 12;
                else if (kind == cht_pkg::KIND_12)
                    h = h >> 10;
                query_hash(h, kind);
            end
            else if (r < 90)
            begin
                h = 22'($urandom);
                if ($urandom_range(0, 1) == 0)
                    h = h & 22'h000FFF;
                query_hash(h, 2'($urandom_range(0, 3)));
            end
            else
            begin
                nm = {$urandom, $urandom, 24'($urandom)};
                nm[cht_pkg::NAME_W-1 -: cht_pkg::CHAR_W] = '0;
                save_callsign(22'($urandom), nm);
            end
        end
    endtask

    initial
    begin
        int                         k;
        int                         waited;
        logic [cht_pkg::NAME_W-1:0] fill_name;
        calm = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // empty table, empty callsign, extremes, early-ended callsigns
        query_hash(22'h000000, cht_pkg::KIND_22);
        save_callsign(22'h3FFFFF, {8'h00, 80'hA5_5A_FF_01_80_7F_3C_C3_99_66});
        save_callsign(22'h000000, {8'h41, 80'h0});
        save_callsign(22'h3FFFFF, '1);
        save_callsign(22'h2AAAAA, {"K1AB", 8'h00, 8'h77, 8'h00, 8'h13, 8'h00, 8'hFE, 8'h01});
        save_callsign(22'h2AAAAA, {"K1AB", 8'h00, 8'hAA, 8'h55, 8'h00, 8'hC0, 8'h00, 8'h7E});
        save_callsign(22'h3FFFFF, '1);
        save_callsign(22'h2AAAAA, {"N0CALL", 40'h0});
        save_callsign(22'h3AAAAA, {"W9XYZ/P", 32'h0});
        query_hash(22'h2AAAAA, cht_pkg::KIND_22);
        query_hash(22'h2AAAAA >> 10, cht_pkg::KIND_12);
        query_hash(22'h2AAAAA >> 12, cht_pkg::KIND_10);
        query_hash(22'h3FFFFF, cht_pkg::KIND_SPARE);
        query_hash(22'h3FFFFF, cht_pkg::KIND_10);
        query_hash(22'h001000, cht_pkg::KIND_12);
        query_hash(22'h000000, cht_pkg::KIND_10);
        query_hash(22'h155555, cht_pkg::KIND_22);
        query_hash(22'h3AAAAA >> 12, cht_pkg::KIND_10);
        save_callsign(22'h15A5A5, {"VK2XYZ/PQRS"});
        query_hash(22'h15A5A5, cht_pkg::KIND_22);
        query_hash(22'h15A5A5 >> 10, cht_pkg::KIND_SPARE);

        random_mix(600);

        // fill until every slot is taken; the tail sees table_full on saves
        for (k = 0; k < 300; k++)
        begin
            if (k % 64 == 0)
                calm = ($urandom_range(0, 3) == 0);
            fill_name = random_callsign();
            fill_name[cht_pkg::NAME_W-1 -: 4*cht_pkg::CHAR_W] =
                {8'h46, 8'h41 + 8'((k / 676) % 26),
                 8'h41 + 8'((k / 26) % 26), 8'h41 + 8'(k % 26)};
            save_callsign(22'($urandom), fill_name);
        end

        random_mix(350);
        start <= 1'b0;

        @(posedge clk);
        waited = 0;
        while (pending != 0 && waited < 20000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (300) @(posedge clk);

        $display("%0d requests sent: %0d saves, %0d lookups", save_count + lookup_count,
                 save_count, lookup_count);
        $display("%0d results checked: %0d hits or refreshes, %0d table-full answers",
                 checked, hits, fulls);
        if (mismatches == 0 && pending == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin
        #25_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

FILE: callsign_hash_table.f
hw/rtl/cht_pkg.sv
hw/rtl/cht_ctrl.sv
hw/rtl/cht_datapath.sv
hw/rtl/callsign_hash_table.sv
hw/rtl/cht_checker.sv
sim/callsign_hash_table_checker.sv
sim/callsign_hash_table_test.sv
